### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the accumulator cpu rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ACPU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ACPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// condition never holds
`define ACPU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// types and constants of the accumulator cpu core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acpu_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 16;
  localparam int OP_W      = 4;
  localparam int CNT_OUT_W = 32;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EXEC  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_COUNT = 2'd3;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 4'h1;
  localparam logic [OP_W-1:0] OP_STORE = 4'h2;
  localparam logic [OP_W-1:0] OP_ADD   = 4'h3;
  localparam logic [OP_W-1:0] OP_SUBT  = 4'h4;
  localparam logic [OP_W-1:0] OP_INPUT = 4'h5;
  localparam logic [OP_W-1:0] OP_OUTP  = 4'h6;
  localparam logic [OP_W-1:0] OP_HALT  = 4'h7;
  localparam logic [OP_W-1:0] OP_SKIP  = 4'h8;
  localparam logic [OP_W-1:0] OP_JUMP  = 4'h9;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'hB;

  // skip condition field
  localparam logic [ADDR_W-1:0] COND_MASK = 12'h0E00;
  localparam logic [ADDR_W-1:0] COND_NEG  = 12'h0000;
  localparam logic [ADDR_W-1:0] COND_ZERO = 12'h0400;
  localparam logic [ADDR_W-1:0] COND_POS  = 12'h0800;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DECODE,
    SEQ_EXEC,
    SEQ_BUMP,
    SEQ_RDMEM,
    SEQ_RDCNT,
    SEQ_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [ADDR_W-1:0]        address;
    logic [WORD_W-1:0]        data;
    logic signed [WORD_W-1:0] input_value;
    logic [OP_W-1:0]          count_opcode;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]        read_data;
    logic [CNT_OUT_W-1:0]     count_value;
    logic [ADDR_W-1:0]        prog_counter;
    logic [WORD_W-1:0]        instr_reg;
    logic signed [WORD_W-1:0] accumulator;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [WORD_W-1:0] buffer_reg;
    logic                     out_valid;
    logic                     halted;
    logic                     fault;
  } res_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic            rd;
    logic            bump;
    logic [OP_W-1:0] idx;
  } cnt_req_t;

endpackage

### rtl/acpu_mem.sv
// ----------------------------------------------------------------------------
// acpu_mem
// single-port program memory with a zeroing pass after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acpu_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acpu_pkg::mem_req_t         req,
  output logic [acpu_pkg::WORD_W-1:0] rdata,
  output logic                       busy
);

  logic [acpu_pkg::WORD_W-1:0] mem_r [acpu_pkg::MEM_WORDS];
  logic [acpu_pkg::WORD_W-1:0] rdata_r;
  logic                        clr_r;
  logic                        clr_nxt;
  logic [acpu_pkg::ADDR_W-1:0] clr_addr_r;
  logic [acpu_pkg::ADDR_W-1:0] clr_addr_nxt;
  logic                        clr_last;

  assign clr_last = (clr_addr_r == acpu_pkg::ADDR_W'(acpu_pkg::MEM_WORDS - 1));

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_last) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // memory array, one access per cycle
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (req.wr) begin
      mem_r[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem_r[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

  `ACPU_ASSERT_NEVER(a_mem_no_req_clr, clk, rst_n, clr_r && (req.rd || req.wr), "access during clear")
  `ACPU_ASSERT_IMPL(a_mem_clr_full, clk, rst_n, $fell(clr_r), $past(clr_last), "clear pass cut short")

endmodule

### rtl/acpu_cnt.sv
// ----------------------------------------------------------------------------
// acpu_cnt
// per-opcode execution counters, saturating read-modify-write store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acpu_cnt #(
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acpu_pkg::cnt_req_t            req,
  output logic [acpu_pkg::CNT_OUT_W-1:0] cnt_value
);

  localparam int N_OPS = 2 ** acpu_pkg::OP_W;

  logic [COUNT_BITS-1:0]     mem_r [N_OPS];
  logic [N_OPS-1:0]          vld_r;
  logic [COUNT_BITS-1:0]     rd_q_r;
  logic [acpu_pkg::OP_W-1:0] last_idx_r;
  logic [COUNT_BITS-1:0]     inc;

  // hold at all ones
  assign inc = (&rd_q_r) ? rd_q_r : rd_q_r + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.bump) begin
      vld_r[last_idx_r] <= 1'b1;
    end
  end

  // bump writes back to the entry read last
  always_ff @(posedge clk) begin
    if (req.bump) begin
      mem_r[last_idx_r] <= inc;
    end
    if (req.rd) begin
      rd_q_r     <= vld_r[req.idx] ? mem_r[req.idx] : '0;
      last_idx_r <= req.idx;
    end
  end

  generate
    if (COUNT_BITS > acpu_pkg::CNT_OUT_W) begin : g_clip
      assign cnt_value = (|rd_q_r[COUNT_BITS-1:acpu_pkg::CNT_OUT_W]) ?
                         '1 : rd_q_r[acpu_pkg::CNT_OUT_W-1:0];
    end else begin : g_ext
      assign cnt_value = acpu_pkg::CNT_OUT_W'(rd_q_r);
    end
  endgenerate

  `ACPU_ASSERT_NEVER(a_cnt_rd_bump, clk, rst_n, req.rd && req.bump, "read and bump together")

endmodule

### rtl/acpu_core.sv
// ----------------------------------------------------------------------------
// acpu_core
// instruction sequencer and architectural registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acpu_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_vld,
  input  acpu_pkg::item_t               item,
  output logic                          take,
  input  logic                          res_free,
  output logic                          res_load,
  output acpu_pkg::res_t                res,
  output acpu_pkg::mem_req_t            mem_req,
  input  logic [acpu_pkg::WORD_W-1:0]   mem_rdata,
  output acpu_pkg::cnt_req_t            cnt_req,
  input  logic [acpu_pkg::CNT_OUT_W-1:0] cnt_value
);

  acpu_pkg::seq_state_t        state_r, state_nxt;
  acpu_pkg::item_t             cur_r, cur_nxt;
  logic [acpu_pkg::ADDR_W-1:0] pc_r, pc_nxt;
  logic [acpu_pkg::ADDR_W-1:0] mar_r, mar_nxt;
  logic [acpu_pkg::WORD_W-1:0] acc_r, acc_nxt;
  logic [acpu_pkg::WORD_W-1:0] mbr_r, mbr_nxt;
  logic [acpu_pkg::WORD_W-1:0] ir_r, ir_nxt;
  logic                        halt_r, halt_nxt;
  logic                        fault_r, fault_nxt;
  logic                        outp_r, outp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acpu_pkg::SEQ_IDLE;
      pc_r    <= '0;
      mar_r   <= '0;
      acc_r   <= '0;
      mbr_r   <= '0;
      ir_r    <= '0;
      halt_r  <= 1'b0;
      fault_r <= 1'b0;
      outp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      mar_r   <= mar_nxt;
      acc_r   <= acc_nxt;
      mbr_r   <= mbr_nxt;
      ir_r    <= ir_nxt;
      halt_r  <= halt_nxt;
      fault_r <= fault_nxt;
      outp_r  <= outp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_comb begin
    logic [acpu_pkg::OP_W-1:0]   op;
    logic [acpu_pkg::ADDR_W-1:0] opnd;
    logic [acpu_pkg::ADDR_W-1:0] cond;
    logic                        skip;

    op        = mem_rdata[acpu_pkg::WORD_W-1 -: acpu_pkg::OP_W];
    opnd      = mem_rdata[acpu_pkg::ADDR_W-1:0];
    cond      = opnd & acpu_pkg::COND_MASK;
    skip      = 1'b0;

    state_nxt = state_r;
    cur_nxt   = cur_r;
    pc_nxt    = pc_r;
    mar_nxt   = mar_r;
    acc_nxt   = acc_r;
    mbr_nxt   = mbr_r;
    ir_nxt    = ir_r;
    halt_nxt  = halt_r;
    fault_nxt = fault_r;
    outp_nxt  = outp_r;
    take      = 1'b0;
    res_load  = 1'b0;
    mem_req   = '0;
    cnt_req   = '0;

    unique case (state_r)
      acpu_pkg::SEQ_IDLE: begin
        if (item_vld) begin
          take     = 1'b1;
          cur_nxt  = item;
          outp_nxt = 1'b0;
          unique case (item.kind)
            acpu_pkg::KIND_WRITE: begin
              mem_req.wr    = 1'b1;
              mem_req.addr  = item.address;
              mem_req.wdata = item.data;
              state_nxt     = acpu_pkg::SEQ_FINISH;
            end
            acpu_pkg::KIND_READ: begin
              mem_req.rd   = 1'b1;
              mem_req.addr = item.address;
              state_nxt    = acpu_pkg::SEQ_RDMEM;
            end
            acpu_pkg::KIND_COUNT: begin
              cnt_req.rd  = 1'b1;
              cnt_req.idx = item.count_opcode;
              state_nxt   = acpu_pkg::SEQ_RDCNT;
            end
            acpu_pkg::KIND_EXEC: begin
              if (halt_r) begin
                state_nxt = acpu_pkg::SEQ_FINISH;
              end else begin
                // fetch
                mem_req.rd   = 1'b1;
                mem_req.addr = pc_r;
                mar_nxt      = pc_r;
                pc_nxt       = pc_r + 1'b1;
                state_nxt    = acpu_pkg::SEQ_DECODE;
              end
            end
          endcase
        end
      end

      acpu_pkg::SEQ_DECODE: begin
        mbr_nxt     = mem_rdata;
        ir_nxt      = mem_rdata;
        cnt_req.rd  = 1'b1;
        cnt_req.idx = op;
        state_nxt   = acpu_pkg::SEQ_BUMP;
        unique case (op)
          acpu_pkg::OP_LOAD, acpu_pkg::OP_ADD, acpu_pkg::OP_SUBT: begin
            mar_nxt      = opnd;
            mem_req.rd   = 1'b1;
            mem_req.addr = opnd;
            state_nxt    = acpu_pkg::SEQ_EXEC;
          end
          acpu_pkg::OP_STORE: begin
            mar_nxt       = opnd;
            mem_req.wr    = 1'b1;
            mem_req.addr  = opnd;
            mem_req.wdata = acc_r;
          end
          acpu_pkg::OP_INPUT: acc_nxt = cur_r.input_value;
          acpu_pkg::OP_OUTP:  outp_nxt = 1'b1;
          acpu_pkg::OP_HALT:  halt_nxt = 1'b1;
          acpu_pkg::OP_SKIP: begin
            if (cond == acpu_pkg::COND_NEG) begin
              skip = acc_r[acpu_pkg::WORD_W-1];
            end else if (cond == acpu_pkg::COND_ZERO) begin
              skip = (acc_r == '0);
            end else if (cond == acpu_pkg::COND_POS) begin
              skip = !acc_r[acpu_pkg::WORD_W-1] && (acc_r != '0);
            end
            if (skip) begin
              pc_nxt = pc_r + 1'b1;
            end
          end
          acpu_pkg::OP_JUMP:  pc_nxt = opnd;
          acpu_pkg::OP_CLEAR: acc_nxt = '0;
          default: begin
            // unsupported opcode, no counter change
            cnt_req.rd = 1'b0;
            halt_nxt   = 1'b1;
            fault_nxt  = 1'b1;
            state_nxt  = acpu_pkg::SEQ_FINISH;
          end
        endcase
      end

      acpu_pkg::SEQ_EXEC: begin
        if (res_free) begin
          mbr_nxt = mem_rdata;
          unique case (ir_r[acpu_pkg::WORD_W-1 -: acpu_pkg::OP_W])
            acpu_pkg::OP_ADD:  acc_nxt = acc_r + mem_rdata;
            acpu_pkg::OP_SUBT: acc_nxt = acc_r - mem_rdata;
            default:           acc_nxt = mem_rdata;
          endcase
          cnt_req.bump = 1'b1;
          res_load     = 1'b1;
          state_nxt    = acpu_pkg::SEQ_IDLE;
        end
      end

      acpu_pkg::SEQ_BUMP: begin
        if (res_free) begin
          cnt_req.bump = 1'b1;
          res_load     = 1'b1;
          state_nxt    = acpu_pkg::SEQ_IDLE;
        end
      end

      acpu_pkg::SEQ_RDMEM, acpu_pkg::SEQ_RDCNT, acpu_pkg::SEQ_FINISH: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = acpu_pkg::SEQ_IDLE;
        end
      end

      default: state_nxt = acpu_pkg::SEQ_IDLE;
    endcase
  end

  // result word shows the registers as they stand after the item
  always_comb begin
    res.read_data    = (state_r == acpu_pkg::SEQ_RDMEM) ? mem_rdata : '0;
    res.count_value  = (state_r == acpu_pkg::SEQ_RDCNT) ? cnt_value : '0;
    res.prog_counter = pc_nxt;
    res.instr_reg    = ir_nxt;
    res.accumulator  = acc_nxt;
    res.addr_reg     = mar_nxt;
    res.buffer_reg   = mbr_nxt;
    res.out_valid    = outp_nxt;
    res.halted       = halt_nxt;
    res.fault        = fault_nxt;
  end

  `ACPU_ASSERT_NEVER(a_core_fault_halt, clk, rst_n, fault_r && !halt_r, "fault without halt")
  `ACPU_ASSERT_NEXT(a_core_halt_sticky, clk, rst_n, halt_r, halt_r, "halt flag cleared")
  `ACPU_ASSERT_NEVER(a_core_load_full, clk, rst_n, res_load && !res_free, "result overrun")

endmodule

### rtl/accumulator_cpu_core_step.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_core_step
// 16-bit accumulator cpu with 4096-word program memory, one item per word
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one item per word: write a
//   memory word, read a memory word, read an opcode's execution count, or
//   execute one instruction. output channel (out_valid / out_stall) returns
//   exactly one result word per item, in order, with the registers after it.
//   an input buffer and an output register decouple the two sides, so a new
//   word is taken while the previous one is still in flight or waiting.
// sequencer steps
//   execute: fetch read, operand read or write, then writeback, an order
//   set by the single port of the program memory. memory write, memory read,
//   count read and execute while halted: the request, then the result step.
//   the result appears in the cycle after the sequencer finishes.
// reset
//   rst_n is synchronous, active low. registers, flags and counters clear at
//   once; the program memory then runs a zeroing pass over all 4096 words
//   during which in_stall stays high.
// stall
//   while out_stall holds a result, the sequencer waits at its last step and
//   the input buffer fills, after which in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_cpu_core_step #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_kind,
  input  logic [acpu_pkg::ADDR_W-1:0]         in_address,
  input  logic [acpu_pkg::WORD_W-1:0]         in_data,
  input  logic signed [acpu_pkg::WORD_W-1:0]  in_input_value,
  input  logic [acpu_pkg::OP_W-1:0]           in_count_opcode,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [acpu_pkg::WORD_W-1:0]         out_read_data,
  output logic [acpu_pkg::CNT_OUT_W-1:0]      out_count_value,
  output logic [acpu_pkg::ADDR_W-1:0]         out_prog_counter,
  output logic [acpu_pkg::WORD_W-1:0]         out_instr_reg,
  output logic signed [acpu_pkg::WORD_W-1:0]  out_accumulator,
  output logic [acpu_pkg::ADDR_W-1:0]         out_addr_reg,
  output logic signed [acpu_pkg::WORD_W-1:0]  out_buffer_reg,
  output logic                                out_out_valid,
  output logic                                out_halted,
  output logic                                out_fault
);

  // input buffer
  logic               buf_vld_r, buf_vld_nxt;
  acpu_pkg::item_t    buf_r;
  logic               in_accept;

  // output register
  logic               out_vld_r, out_vld_nxt;
  acpu_pkg::res_t     res_r;
  logic               res_free;

  // sequencer links
  logic                          take;
  logic                          res_load;
  acpu_pkg::res_t                res;
  acpu_pkg::mem_req_t            mem_req;
  logic [acpu_pkg::WORD_W-1:0]   mem_rdata;
  logic                          mem_busy;
  acpu_pkg::cnt_req_t            cnt_req;
  logic [acpu_pkg::CNT_OUT_W-1:0] cnt_value;

  // stall is registered: buffer full or memory still being zeroed
  assign in_stall  = buf_vld_r || mem_busy;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    buf_vld_nxt = buf_vld_r;
    if (in_accept) begin
      buf_vld_nxt = 1'b1;
    end else if (take) begin
      buf_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      buf_r.kind         <= in_kind;
      buf_r.address      <= in_address;
      buf_r.data         <= in_data;
      buf_r.input_value  <= in_input_value;
      buf_r.count_opcode <= in_count_opcode;
    end
  end

  // result slot free when empty or being taken this cycle
  assign res_free = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      buf_vld_r <= buf_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  acpu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (buf_vld_r),
    .item      (buf_r),
    .take      (take),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .cnt_req   (cnt_req),
    .cnt_value (cnt_value)
  );

  acpu_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  acpu_cnt #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (cnt_req),
    .cnt_value (cnt_value)
  );

  assign out_valid        = out_vld_r;
  assign out_read_data    = res_r.read_data;
  assign out_count_value  = res_r.count_value;
  assign out_prog_counter = res_r.prog_counter;
  assign out_instr_reg    = res_r.instr_reg;
  assign out_accumulator  = res_r.accumulator;
  assign out_addr_reg     = res_r.addr_reg;
  assign out_buffer_reg   = res_r.buffer_reg;
  assign out_out_valid    = res_r.out_valid;
  assign out_halted       = res_r.halted;
  assign out_fault        = res_r.fault;

endmodule

### test/acpu_step_checker.sv
// ----------------------------------------------------------------------------
// acpu_step_checker
// watches both channels of the accumulator cpu core, predicts each result
// word from its own copy of memory, registers and counters, and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acpu_step_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [1:0]                          in_kind,
  input  logic [acpu_pkg::ADDR_W-1:0]         in_address,
  input  logic [acpu_pkg::WORD_W-1:0]         in_data,
  input  logic signed [acpu_pkg::WORD_W-1:0]  in_input_value,
  input  logic [acpu_pkg::OP_W-1:0]           in_count_opcode,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [acpu_pkg::WORD_W-1:0]         out_read_data,
  input  logic [acpu_pkg::CNT_OUT_W-1:0]      out_count_value,
  input  logic [acpu_pkg::ADDR_W-1:0]         out_prog_counter,
  input  logic [acpu_pkg::WORD_W-1:0]         out_instr_reg,
  input  logic signed [acpu_pkg::WORD_W-1:0]  out_accumulator,
  input  logic [acpu_pkg::ADDR_W-1:0]         out_addr_reg,
  input  logic signed [acpu_pkg::WORD_W-1:0]  out_buffer_reg,
  input  logic                                out_out_valid,
  input  logic                                out_halted,
  input  logic                                out_fault,
  output int unsigned                         failures,
  output int unsigned                         pending
);
  import acpu_pkg::*;

  // shadow machine
  logic [WORD_W-1:0]    mem_img [MEM_WORDS];
  logic [WORD_W-1:0]    acc_r, mbr_r, ir_r;
  logic [ADDR_W-1:0]    pc_r, mar_r;
  logic [CNT_OUT_W-1:0] exec_tally [1 << OP_W];
  logic                 halt_r, fault_r;

  res_t  snapshot_q [$];
  res_t  want;
  item_t taken;

  function automatic res_t advance_cpu(input item_t it);
    res_t              r;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] arg;
    logic              known, skip;
    r = '0;
    case (it.kind)
      KIND_WRITE: mem_img[it.address] = it.data;
      KIND_READ:  r.read_data = mem_img[it.address];
      KIND_COUNT: r.count_value = exec_tally[it.count_opcode];
      KIND_EXEC: begin
        if (!halt_r) begin
          // fetch always lands, even for an opcode that then faults
          mar_r = pc_r;
          mbr_r = mem_img[pc_r];
          ir_r  = mbr_r;
          pc_r  = pc_r + 1'b1;
          op    = ir_r[WORD_W-1 -: OP_W];
          arg   = ir_r[ADDR_W-1:0];
          known = 1'b1;
          skip  = 1'b0;
          case (op)
            OP_LOAD: begin
              mar_r = arg;
              mbr_r = mem_img[arg];
              acc_r = mbr_r;
            end
            OP_STORE: begin
              mar_r = arg;
              mem_img[arg] = acc_r;
            end
            OP_ADD: begin
              mar_r = arg;
              mbr_r = mem_img[arg];
              acc_r = acc_r + mbr_r;
            end
            OP_SUBT: begin
              mar_r = arg;
              mbr_r = mem_img[arg];
              acc_r = acc_r - mbr_r;
            end
            OP_INPUT: acc_r = it.input_value;
            OP_OUTP:  r.out_valid = 1'b1;
            OP_HALT:  halt_r = 1'b1;
            OP_SKIP: begin
              case (arg & COND_MASK)
                COND_NEG:  skip = acc_r[WORD_W-1];
                COND_ZERO: skip = (acc_r == '0);
                COND_POS:  skip = !acc_r[WORD_W-1] && (acc_r != '0);
                default:   skip = 1'b0;
              endcase
              if (skip) pc_r = pc_r + 1'b1;
            end
            OP_JUMP:  pc_r = arg;
            OP_CLEAR: acc_r = '0;
            default: begin
              halt_r  = 1'b1;
              fault_r = 1'b1;
              known   = 1'b0;
            end
          endcase
          if (known && exec_tally[op] != '1) exec_tally[op] = exec_tally[op] + 1'b1;
        end
      end
    endcase
    r.prog_counter = pc_r;
    r.instr_reg    = ir_r;
    r.accumulator  = acc_r;
    r.addr_reg     = mar_r;
    r.buffer_reg   = mbr_r;
    r.halted       = halt_r;
    r.fault        = fault_r;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_OUT_W-1:0] want_v,
                             input logic [CNT_OUT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MEM_WORDS; k++) mem_img[k] = '0;
      for (int k = 0; k < (1 << OP_W); k++) exec_tally[k] = '0;
      acc_r   = '0;
      mbr_r   = '0;
      ir_r    = '0;
      pc_r    = '0;
      mar_r   = '0;
      halt_r  = 1'b0;
      fault_r = 1'b0;
      snapshot_q.delete();
      failures = 0;
    end else begin
      // results first, so a stray word never meets this edge's prediction
      if (out_valid && !out_stall) begin
        if (snapshot_q.size() == 0) begin
          $error("result word with no expectation pending");
          failures++;
        end else begin
          want = snapshot_q.pop_front();
          check_field("read_data",    want.read_data,              out_read_data);
          check_field("count_value",  want.count_value,            out_count_value);
          check_field("prog_counter", want.prog_counter,           out_prog_counter);
          check_field("instr_reg",    want.instr_reg,              out_instr_reg);
          check_field("accumulator",  $unsigned(want.accumulator), $unsigned(out_accumulator));
          check_field("addr_reg",     want.addr_reg,               out_addr_reg);
          check_field("buffer_reg",   $unsigned(want.buffer_reg),  $unsigned(out_buffer_reg));
          check_field("out_valid",    want.out_valid,              out_out_valid);
          check_field("halted",       want.halted,                 out_halted);
          check_field("fault",        want.fault,                  out_fault);
        end
      end
      if (in_valid && !in_stall) begin
        taken = {in_kind, in_address, in_data, in_input_value, in_count_opcode};
        snapshot_q.push_back(advance_cpu(taken));
      end
    end
    pending <= snapshot_q.size();
  end

endmodule

### test/accumulator_cpu_core_step_test.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_core_step_test
// drives the accumulator cpu core with a directed program, then a long run of
// random programs confined to a small code area, and finally stops the cpu;
// a checker beside the core predicts and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_cpu_core_step_test;
  import acpu_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS  = 125;        // words per idling phase
  localparam int HOLD_AT      = 510;        // falls in a phase with no idling
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int RUN_LIMIT_NS = 4_000_000;

  // random programs live in the bottom of memory, data in the top half
  localparam int                CODE_WORDS = 64;
  localparam logic [ADDR_W-1:0] DATA_BASE  = 12'h800;

  // opcodes with no instruction behind them
  localparam int                NUM_UNUSED = 6;
  localparam logic [NUM_UNUSED*OP_W-1:0] UNUSED_OPS = {4'hF, 4'hE, 4'hD, 4'hC, 4'hA, 4'h0};

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_kind         = KIND_READ;
  logic [ADDR_W-1:0]          in_address      = '0;
  logic [WORD_W-1:0]          in_data         = '0;
  logic signed [WORD_W-1:0]   in_input_value  = '0;
  logic [OP_W-1:0]            in_count_opcode = '0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic [WORD_W-1:0]          out_read_data;
  logic [CNT_OUT_W-1:0]       out_count_value;
  logic [ADDR_W-1:0]          out_prog_counter;
  logic [WORD_W-1:0]          out_instr_reg;
  logic signed [WORD_W-1:0]   out_accumulator;
  logic [ADDR_W-1:0]          out_addr_reg;
  logic signed [WORD_W-1:0]   out_buffer_reg;
  logic                       out_out_valid;
  logic                       out_halted;
  logic                       out_fault;

  idle_mode_t  idle_mode = IDLE_NONE;
  logic        hold_req  = 1'b0;
  int unsigned hold_left = HOLD_CYCLES;
  int unsigned fail_total;
  int unsigned in_flight;

  always #(CLK_HALF_NS) clk = ~clk;

  accumulator_cpu_core_step i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_data          (in_data),
    .in_input_value   (in_input_value),
    .in_count_opcode  (in_count_opcode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_count_value  (out_count_value),
    .out_prog_counter (out_prog_counter),
    .out_instr_reg    (out_instr_reg),
    .out_accumulator  (out_accumulator),
    .out_addr_reg     (out_addr_reg),
    .out_buffer_reg   (out_buffer_reg),
    .out_out_valid    (out_out_valid),
    .out_halted       (out_halted),
    .out_fault        (out_fault)
  );

  acpu_step_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_data          (in_data),
    .in_input_value   (in_input_value),
    .in_count_opcode  (in_count_opcode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_count_value  (out_count_value),
    .out_prog_counter (out_prog_counter),
    .out_instr_reg    (out_instr_reg),
    .out_accumulator  (out_accumulator),
    .out_addr_reg     (out_addr_reg),
    .out_buffer_reg   (out_buffer_reg),
    .out_out_valid    (out_out_valid),
    .out_halted       (out_halted),
    .out_fault        (out_fault),
    .failures         (fail_total),
    .pending          (in_flight)
  );

  // result side: one long hold-off when asked, otherwise stalls by phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_left != 0) begin
      // sender keeps offering meanwhile, so the core fills and stalls its input
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 54);
        IDLE_BOTH:     out_stall <= ($urandom_range(99) < 35);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // offer one word, idling first by phase, and hold it until it is taken;
  // in_stall is read just after the edge, i.e. the value the core saw
  task automatic offer(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                       input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] ival,
                       input logic [OP_W-1:0] cop);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 54 : (idle_mode == IDLE_BOTH) ? 35 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_address      <= addr;
    in_data         <= data;
    in_input_value  <= ival;
    in_count_opcode <= cop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // fields a kind does not use carry random bits
  task automatic put_word(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    offer(KIND_WRITE, addr, data, WORD_W'($urandom), OP_W'($urandom));
  endtask

  task automatic get_word(input logic [ADDR_W-1:0] addr);
    offer(KIND_READ, addr, WORD_W'($urandom), WORD_W'($urandom), OP_W'($urandom));
  endtask

  task automatic step_cpu(input logic [WORD_W-1:0] ival);
    offer(KIND_EXEC, ADDR_W'($urandom), WORD_W'($urandom), ival, OP_W'($urandom));
  endtask

  task automatic get_count(input logic [OP_W-1:0] op);
    offer(KIND_COUNT, ADDR_W'($urandom), WORD_W'($urandom), WORD_W'($urandom), op);
  endtask

  // an instruction that keeps the cpu running: stores only hit the data half,
  // jumps only land in the code area, never halt nor an unused opcode
  function automatic logic [WORD_W-1:0] random_instr();
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] arg;
    int unsigned       pick;
    pick = $urandom_range(99);
    arg  = ADDR_W'($urandom);
    if (pick < 12) begin
      op = OP_LOAD;
    end else if (pick < 22) begin
      op  = OP_STORE;
      arg = arg | DATA_BASE;
    end else if (pick < 36) begin
      op = OP_ADD;
    end else if (pick < 48) begin
      op = OP_SUBT;
    end else if (pick < 60) begin
      op = OP_INPUT;
    end else if (pick < 68) begin
      op = OP_OUTP;
    end else if (pick < 84) begin
      op = OP_SKIP;
      // mostly a real condition, now and then one that never skips
      case ($urandom_range(3))
        0:       arg = (arg & ~COND_MASK) | COND_NEG;
        1:       arg = (arg & ~COND_MASK) | COND_ZERO;
        2:       arg = (arg & ~COND_MASK) | COND_POS;
        default: ;
      endcase
    end else if (pick < 90) begin
      op  = OP_JUMP;
      arg = ADDR_W'($urandom_range(CODE_WORDS - 1));
    end else begin
      op = OP_CLEAR;
    end
    return {op, arg};
  endfunction

  initial begin
    logic [WORD_W-1:0] stop_word;
    int unsigned       pick;
    int unsigned       bad_idx;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed program in the top words, wrapping back to address 0 ----
    put_word(12'h800, 16'hFFFF);
    put_word(12'h801, 16'hFFFF);
    put_word(12'h000, {OP_JUMP, 12'hFF9});
    put_word(12'hFF9, {OP_INPUT, 12'h000});
    put_word(12'hFFA, {OP_OUTP, 12'h000});
    put_word(12'hFFB, {OP_SKIP, COND_NEG});   // taken: accumulator is negative
    put_word(12'hFFC, {OP_LOAD, 12'h800});    // skipped over
    put_word(12'hFFD, {OP_ADD, 12'h800});     // 0x8000 + 0xFFFF wraps
    put_word(12'hFFE, {OP_SUBT, 12'h801});    // 0x7FFF - 0xFFFF wraps
    put_word(12'hFFF, {OP_STORE, 12'h802});   // fetch here wraps the pc to 0
    step_cpu(16'h0000);
    step_cpu(16'h8000);                       // most negative input
    step_cpu(16'h7FFF);                       // output word
    step_cpu(16'h7FFF);
    step_cpu(16'h0000);
    step_cpu(16'hFFFF);
    step_cpu(16'h0000);
    get_word(12'h802);
    get_word(12'hFFF);
    get_count(UNUSED_OPS[OP_W-1:0]);
    get_count(OP_SKIP);

    // ---- load a random program, ending in two jumps back into it ----
    idle_mode <= IDLE_BOTH;
    for (int a = 0; a < CODE_WORDS - 2; a++) put_word(ADDR_W'(a), random_instr());
    for (int a = CODE_WORDS - 2; a < CODE_WORDS; a++)
      put_word(ADDR_W'(a), {OP_JUMP, ADDR_W'($urandom_range(CODE_WORDS - 3))});

    // ---- random run: mostly execution, with data, code patches and reads ----
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) idle_mode <= idle_mode_t'((i / PHASE_ITEMS) % 4);
      if (i == HOLD_AT) hold_req <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 55) begin
        step_cpu(WORD_W'($urandom));
      end else if (pick < 70) begin
        put_word(DATA_BASE | ADDR_W'($urandom_range(DATA_BASE - 1)), WORD_W'($urandom));
      end else if (pick < 75) begin
        // the closing jumps stay in place
        put_word(ADDR_W'($urandom_range(CODE_WORDS - 3)), random_instr());
      end else if (pick < 90) begin
        get_word(ADDR_W'($urandom));
      end else begin
        get_count(OP_W'($urandom));
      end
    end

    // ---- stop the cpu: halt or an unused opcode over the whole code area ----
    idle_mode <= IDLE_BOTH;
    if ($urandom_range(1) == 0) begin
      stop_word = {OP_HALT, ADDR_W'($urandom)};
    end else begin
      bad_idx   = $urandom_range(NUM_UNUSED - 1);
      stop_word = {UNUSED_OPS[bad_idx*OP_W +: OP_W], ADDR_W'($urandom)};
    end
    for (int a = 0; a < CODE_WORDS; a++) put_word(ADDR_W'(a), stop_word);
    // first one stops it, the rest must change nothing
    for (int n = 0; n < 4; n++) step_cpu(WORD_W'($urandom));
    // memory and counters still answer while stopped
    put_word(DATA_BASE, WORD_W'($urandom));
    get_word(DATA_BASE);
    get_word(ADDR_W'($urandom_range(CODE_WORDS - 1)));
    for (int op = 0; op < (1 << OP_W); op++) get_count(OP_W'(op));
    in_valid <= 1'b0;

    // let the checker count the last word, drain, then watch for strays
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_total == 0) begin
      $display("accumulator_cpu_core_step_test: PASS");
    end else begin
      $display("accumulator_cpu_core_step_test: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run including the clearing pass
  initial begin
    #(RUN_LIMIT_NS);
    $display("accumulator_cpu_core_step_test: FAIL");
    $finish;
  end

endmodule
